// File: src/sxb_pkg.sv
// Shared types, constants and helpers for the sprite XOR blitter.
// No dependencies; every other file imports this package.
package sxb_pkg;

    localparam int LINE_W          = 64;
    localparam int DIGIT_W         = 8;
    localparam int DIGITS          = LINE_W / DIGIT_W;
    localparam int DIG_IDX_W       = $clog2(DIGITS);
    localparam int STEP_W          = DIG_IDX_W + 1;
    localparam int SCREEN_LINES    = 32;
    localparam int LINE_IDX_W      = $clog2(SCREEN_LINES);
    localparam int MAX_SPRITE_ROWS = 16;
    localparam int ADDR_W          = LINE_IDX_W + DIG_IDX_W;
    localparam int MEM_DEPTH       = SCREEN_LINES * DIGITS;

    // Start line is masked to 0..31, start column to 0..63.
    localparam int Y_MASK_W        = 5;
    localparam int X_MASK_W        = 6;
    localparam int DRAW_LINE_W     = Y_MASK_W + 1;
    localparam int CMP_W           = 9;
    localparam int WIN_W           = 2 * DIGIT_W;

    localparam logic [1:0] CMD_DRAW  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] x_coord;
        logic [7:0] y_coord;
        logic [3:0] row_offset;
        logic [7:0] sprite_row;
        logic       last_row;
    } sxb_req_t;

    typedef struct packed {
        logic              collision;
        logic [LINE_W-1:0] line_pixels;
    } sxb_rsp_t;

    // Frame memory control from the sequencer.
    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [DIGIT_W-1:0]    wr_data;
        logic                  clr_all;
        logic                  set_valid;
        logic [LINE_IDX_W-1:0] set_line;
    } sxb_mem_ctl_t;

    // Leftmost sprite pixel (MSB) goes to the lowest column.
    function automatic logic [7:0] mirror_byte(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = b[i];
        end
        return r;
    endfunction

endpackage

// File: src/sxb_frame_mem.sv
// Framebuffer store: one byte per entry, eight entries per line, per-line valid bits.
// Depends on sxb_pkg.
module sxb_frame_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sxb_pkg::sxb_mem_ctl_t         ctl,
    output logic [sxb_pkg::DIGIT_W-1:0]   rd_data
);
    import sxb_pkg::*;

    logic [DIGIT_W-1:0]      mem [MEM_DEPTH];
    logic [DIGIT_W-1:0]      rd_data_reg;
    logic                    rd_ok_reg;
    logic [SCREEN_LINES-1:0] valid_reg;
    logic [SCREEN_LINES-1:0] valid_next;

    always_ff @(posedge clk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    // Unwritten lines read as blank.
    always_comb begin
        valid_next = valid_reg;
        if (ctl.clr_all) begin
            valid_next = '0;
        end else if (ctl.set_valid) begin
            valid_next[ctl.set_line] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (ctl.rd_en) begin
                rd_ok_reg <= valid_reg[ctl.rd_addr[ADDR_W-1:DIG_IDX_W]];
            end
        end
    end

    assign rd_data = rd_ok_reg ? rd_data_reg : '0;

endmodule

// File: src/sxb_digit_path.sv
// Byte-serial XOR datapath: sprite mask window, per-byte XOR and hit, line shifter.
// Depends on sxb_pkg.
module sxb_digit_path (
    input  logic                            clk,
    input  logic                            load,
    input  logic [sxb_pkg::WIN_W-1:0]       win_in,
    input  logic [sxb_pkg::DIG_IDX_W-1:0]   xd_in,
    input  logic                            step,
    input  logic [sxb_pkg::DIG_IDX_W-1:0]   dig_idx,
    input  logic [sxb_pkg::DIGIT_W-1:0]     rd_data,
    output logic [sxb_pkg::DIGIT_W-1:0]     wr_data,
    output logic                            dig_hit,
    output logic [sxb_pkg::LINE_W-1:0]      line_pixels
);
    import sxb_pkg::*;

    logic [WIN_W-1:0]     win_reg;
    logic [DIG_IDX_W-1:0] xd_reg;
    logic [LINE_W-1:0]    line_reg;
    logic [DIGIT_W-1:0]   mask_dig;
    logic [DIG_IDX_W:0]   dig_ext;
    logic [DIG_IDX_W:0]   xd_ext;

    assign dig_ext = {1'b0, dig_idx};
    assign xd_ext  = {1'b0, xd_reg};

    // Window spans at most two bytes; upper byte past the last column drops out.
    always_comb begin
        mask_dig = '0;
        if (dig_ext == xd_ext) begin
            mask_dig = win_reg[DIGIT_W-1:0];
        end else if (dig_ext == xd_ext + 1'b1) begin
            mask_dig = win_reg[WIN_W-1:DIGIT_W];
        end
    end

    assign wr_data = rd_data ^ mask_dig;
    assign dig_hit = |(rd_data & mask_dig);

    always_ff @(posedge clk) begin
        if (load) begin
            win_reg <= win_in;
            xd_reg  <= xd_in;
        end
        if (step) begin
            line_reg <= {rd_data, line_reg[LINE_W-1:DIGIT_W]};
        end
    end

    assign line_pixels = line_reg;

endmodule

// File: src/sprite_xor_blitter_unit.sv
// Sprite XOR blitter: 64-pixel-wide framebuffer, byte-serial draw and line read.
// Draw and in-range read walk the line's eight bytes through the one-read, one-write byte memory;
// clear, clipped draw, out-of-range read and unused cmd go straight to the response stage.
// A new request is taken only once the last one's result is in the response register.
// Reset (rst_n low, async): screen blank via line valid bits, hit flag 0, no response.
// Depends on sxb_pkg, sxb_frame_mem, sxb_digit_path.
module sprite_xor_blitter_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  sxb_pkg::sxb_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output sxb_pkg::sxb_rsp_t rsp
);
    import sxb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [LINE_IDX_W-1:0] line_reg, line_next;
    logic                  is_draw_reg, is_draw_next;
    logic                  is_read_reg, is_read_next;
    logic                  hit_reg, hit_next;
    logic                  out_vld_reg, out_vld_next;
    sxb_rsp_t              out_reg;

    logic                  req_acc;
    logic                  out_load;
    logic                  proc;
    logic [DRAW_LINE_W-1:0] draw_line;
    logic                  draw_ok;
    logic                  read_ok;
    logic                  row_ok;

    sxb_mem_ctl_t          mem_ctl;
    logic [DIGIT_W-1:0]    rd_data;
    logic [DIGIT_W-1:0]    wr_data;
    logic                  dig_hit;
    logic [LINE_W-1:0]     line_pixels;
    logic [DIG_IDX_W-1:0]  proc_idx;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_acc   = req_valid && !req_stall;

    // Target line of a draw row; clipped when past the last screen line.
    assign draw_line = DRAW_LINE_W'(req.y_coord[Y_MASK_W-1:0]) + DRAW_LINE_W'(req.row_offset);
    assign row_ok    = CMP_W'(req.row_offset) < CMP_W'(MAX_SPRITE_ROWS);
    assign draw_ok   = CMP_W'(draw_line) < CMP_W'(SCREEN_LINES);
    assign read_ok   = CMP_W'(req.y_coord) < CMP_W'(SCREEN_LINES);

    // Step k reads byte k; byte k-1 is XORed and written back in the same cycle.
    assign proc     = (state_reg == ST_RUN) && (step_reg != '0);
    assign proc_idx = DIG_IDX_W'(step_reg - 1'b1);

    // Response register frees the request side while a result waits.
    assign out_load = (state_reg == ST_FIN) && (!out_vld_reg || !rsp_stall);

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        line_next    = line_reg;
        is_draw_next = is_draw_reg;
        is_read_next = is_read_reg;
        hit_next     = hit_reg;
        out_vld_next = out_vld_reg;

        mem_ctl           = '0;
        mem_ctl.rd_addr   = {line_reg, step_reg[DIG_IDX_W-1:0]};
        mem_ctl.wr_addr   = {line_reg, proc_idx};
        mem_ctl.wr_data   = wr_data;
        mem_ctl.set_line  = line_reg;

        if (out_vld_reg && !rsp_stall) begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc) begin
                    step_next    = '0;
                    is_draw_next = 1'b0;
                    is_read_next = 1'b0;
                    state_next   = ST_FIN;
                    unique case (req.cmd)
                        CMD_DRAW:
                        begin
                            if (row_ok) begin
                                if (req.row_offset == '0) begin
                                    hit_next = 1'b0;
                                end
                                if (draw_ok) begin
                                    line_next    = draw_line[LINE_IDX_W-1:0];
                                    is_draw_next = 1'b1;
                                    state_next   = ST_RUN;
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            mem_ctl.clr_all = 1'b1;
                        end
                        CMD_READ:
                        begin
                            if (read_ok) begin
                                line_next    = req.y_coord[LINE_IDX_W-1:0];
                                is_read_next = 1'b1;
                                state_next   = ST_RUN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                mem_ctl.rd_en = (step_reg < STEP_W'(DIGITS));
                mem_ctl.wr_en = proc && is_draw_reg;
                if (proc && is_draw_reg && dig_hit) begin
                    hit_next = 1'b1;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIGITS)) begin
                    mem_ctl.set_valid = is_draw_reg;
                    state_next        = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_load) begin
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            line_reg    <= '0;
            is_draw_reg <= 1'b0;
            is_read_reg <= 1'b0;
            hit_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            line_reg    <= line_next;
            is_draw_reg <= is_draw_next;
            is_read_reg <= is_read_next;
            hit_reg     <= hit_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload: collision is the flag after this request; pixels only for a read.
    always_ff @(posedge clk) begin
        if (out_load) begin
            out_reg.collision   <= hit_reg;
            out_reg.line_pixels <= is_read_reg ? line_pixels : '0;
        end
    end

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

    sxb_frame_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .rd_data (rd_data)
    );

    sxb_digit_path u_path (
        .clk         (clk),
        .load        (req_acc),
        .win_in      (WIN_W'(mirror_byte(req.sprite_row)) << req.x_coord[DIG_IDX_W-1:0]),
        .xd_in       (req.x_coord[X_MASK_W-1:DIG_IDX_W]),
        .step        (proc),
        .dig_idx     (proc_idx),
        .rd_data     (rd_data),
        .wr_data     (wr_data),
        .dig_hit     (dig_hit),
        .line_pixels (line_pixels)
    );

endmodule

// File: src/sxb_checker.sv
// Port-level checks for sprite_xor_blitter_unit, attached by bind.
// Depends on sxb_pkg and the top level's ports.
module sxb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input sxb_pkg::sxb_req_t req,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input sxb_pkg::sxb_rsp_t rsp
);
    import sxb_pkg::*;

    logic       req_acc;
    logic       rsp_acc;
    logic [1:0] pend_reg, pend_next;

    assign req_acc = req_valid && !req_stall;
    assign rsp_acc = rsp_valid && !rsp_stall;

    // Requests accepted but not yet answered.
    always_comb begin
        pend_next = pend_reg;
        if (req_acc && !rsp_acc) begin
            pend_next = pend_reg + 1'b1;
        end else if (!req_acc && rsp_acc) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed or dropped");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> req_stall)
        else $error("request side not busy after accepting a request");

    a_no_spurious_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("response without an outstanding request");

    a_one_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |-> pend_reg == 2'd0 || pend_reg == 2'd1)
        else $error("request accepted with more than one result waiting");

endmodule

bind sprite_xor_blitter_unit sxb_checker u_sxb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// File: tb/tb_top.sv
// Self-checking testbench for sprite_xor_blitter_unit: draw, clear and line read requests.
// Uses types and command codes from sxb_pkg; a local frame model predicts responses not typed in.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sxb_pkg::*;

    // Command code that the package leaves unnamed; the block must treat it as a no-op.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_REQS  = 1700;  // random requests before the run winds down
    localparam int QUIET_FROM   = 1500;  // no idling on either side from here on
    localparam int HOLD_AT      = 500;   // long receiver hold-off starts here
    localparam int DRAIN_AT     = 1000;  // sender pauses until all responses are in
    localparam int HOLD_CYCLES  = 200;
    localparam int TAIL_CYCLES  = 20;
    localparam int PRINT_LIMIT  = 100;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    sxb_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    sxb_rsp_t rsp;

    sprite_xor_blitter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Frame model: 32 lines of 64 pixels plus the running collision flag.
    // ------------------------------------------------------------------
    logic [LINE_W-1:0] frame_model [SCREEN_LINES];
    logic              hit_model;

    sxb_rsp_t pending_rsps [$];     // expected responses, oldest first
    int       mismatches  = 0;
    int       reqs_sent   = 0;      // requests that do real work (unused cmd excluded)
    bit       tx_idle_en  = 1'b1;
    bit       rx_idle_en  = 1'b1;
    bit       hold_request = 1'b0;  // sender asks the receiver for a long hold-off

    // Applies one request to the frame model and returns the response it must produce.
    function automatic sxb_rsp_t predict_blit(input sxb_req_t r);
        sxb_rsp_t          res;
        logic [7:0]        flipped;
        logic [5:0]        line;
        logic [LINE_W-1:0] mask;
        logic [LINE_W-1:0] old;
        res = '0;
        if (r.cmd == CMD_DRAW) begin
            if (r.row_offset < MAX_SPRITE_ROWS) begin
                if (r.row_offset == 4'd0)
                    hit_model = 1'b0;
                line = {1'b0, r.y_coord[4:0]} + {2'b00, r.row_offset};
                // Lines past the bottom are clipped and leave the flag alone.
                if (line < SCREEN_LINES) begin
                    for (int i = 0; i < 8; i++)
                        flipped[i] = r.sprite_row[7 - i];
                    // Shifting drops pixels past column 63: right-edge clip.
                    mask = {56'd0, flipped} << r.x_coord[5:0];
                    old = frame_model[line[4:0]];
                    frame_model[line[4:0]] = old ^ mask;
                    if ((old & mask) != '0)
                        hit_model = 1'b1;
                end
            end
        end else if (r.cmd == CMD_CLEAR) begin
            for (int i = 0; i < SCREEN_LINES; i++)
                frame_model[i] = '0;
        end else if (r.cmd == CMD_READ) begin
            // Read index is not masked; out-of-range lines read as blank.
            if (r.y_coord < SCREEN_LINES)
                res.line_pixels = frame_model[r.y_coord[4:0]];
        end
        res.collision = hit_model;
        return res;
    endfunction

    function automatic sxb_req_t mk_req(input logic [1:0] cmd, input logic [7:0] x,
                                        input logic [7:0] y, input logic [3:0] off,
                                        input logic [7:0] bits, input logic last);
        sxb_req_t r;
        r.cmd        = cmd;
        r.x_coord    = x;
        r.y_coord    = y;
        r.row_offset = off;
        r.sprite_row = bits;
        r.last_row   = last;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t ns: %s mismatch, got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Sender. Called at a falling edge, returns at a falling edge. The
    // request is held until the edge where stall is low; at that edge the
    // model is stepped and the expectation queued. A typed expectation,
    // where given, is queued in place of the model's one.
    // ------------------------------------------------------------------
    task automatic send_req(input sxb_req_t r, input bit typed, input sxb_rsp_t typed_rsp);
        sxb_rsp_t predicted;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        req       = r;
        req_valid = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = predict_blit(r);
        pending_rsps.push_back(typed ? typed_rsp : predicted);
        if (r.cmd != CMD_UNUSED)
            reqs_sent++;
        @(negedge clk);
    endtask

    task automatic send(input sxb_req_t r);
        send_req(r, 1'b0, '0);
    endtask

    // Sender goes quiet until every outstanding response has come back.
    task automatic drain_rsps();
        req_valid = 1'b0;
        while (pending_rsps.size() != 0)
            @(negedge clk);
    endtask

    // Start column: mostly a few hot spots so sprites overlap and collide,
    // sometimes the right edge so clipping is hit; upper bits random to
    // exercise masking.
    function automatic logic [7:0] pick_x();
        logic [5:0] col;
        case ($urandom_range(0, 3))
            0:       col = 6'($urandom_range(56, 63));
            1:       col = 6'($urandom);
            default: col = 6'($urandom_range(0, 7) * 4);
        endcase
        return {2'($urandom), col};
    endfunction

    function automatic logic [7:0] pick_y();
        logic [4:0] ln;
        if ($urandom_range(0, 3) == 0)
            ln = 5'($urandom_range(20, 31));   // near the bottom, rows get clipped
        else
            ln = 5'($urandom_range(0, 11));
        return {3'($urandom), ln};
    endfunction

    function automatic logic [7:0] pick_bits();
        case ($urandom_range(0, 7))
            0:       return 8'hFF;
            1:       return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    // One sprite: rows 0..n-1 at the same start, last_row on the final row.
    // Broken sprites scramble offsets and last_row; good ones are often
    // followed by a read at the line of one of their rows, which may lie below the screen.
    task automatic draw_sprite(input bit broken);
        int         rows;
        logic [7:0] x;
        logic [7:0] y;
        logic [3:0] off;
        logic       last;
        rows = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_SPRITE_ROWS)
                                           : $urandom_range(1, 5);
        x = pick_x();
        y = pick_y();
        for (int k = 0; k < rows; k++) begin
            off  = broken && $urandom_range(0, 1) ? 4'($urandom) : 4'(k);
            last = broken ? 1'($urandom) : (k == rows - 1);
            send(mk_req(CMD_DRAW, x, y, off, pick_bits(), last));
        end
        if (!broken && $urandom_range(0, 1) == 0)
            send(mk_req(CMD_READ, 8'($urandom), {3'd0, y[4:0]} + 8'($urandom_range(0, rows - 1)),
                        4'($urandom), 8'($urandom), 1'($urandom)));
    endtask

    // ------------------------------------------------------------------
    // Directed table: one row per request. Where the response is obvious
    // it is typed in; otherwise the model supplies it.
    // ------------------------------------------------------------------
    typedef struct {
        sxb_req_t r;
        bit       typed;
        sxb_rsp_t rsp;
    } stim_row_t;

    stim_row_t stim_table [$];

    function automatic void add_row(input logic [1:0] cmd, input logic [7:0] x,
                                    input logic [7:0] y, input logic [3:0] off,
                                    input logic [7:0] bits, input logic last,
                                    input bit typed, input logic col,
                                    input logic [63:0] pix);
        stim_row_t row;
        row.r     = mk_req(cmd, x, y, off, bits, last);
        row.typed = typed;
        row.rsp   = {col, pix};
        stim_table.push_back(row);
    endfunction

    function automatic void load_directed();
        // blank screen after reset, first and last line
        add_row(CMD_READ,   8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 1'b1, 1'b0, 64'h0);
        add_row(CMD_READ,   8'd0,   8'd31,  4'd0,  8'h00, 1'b0, 1'b1, 1'b0, 64'h0);
        // leftmost pixel at the top-left corner, then erased again: collision
        add_row(CMD_DRAW,   8'd0,   8'd0,   4'd0,  8'h80, 1'b1, 1'b1, 1'b0, 64'h0);
        add_row(CMD_READ,   8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 1'b1, 1'b0, 64'h1);
        add_row(CMD_DRAW,   8'd0,   8'd0,   4'd0,  8'h80, 1'b1, 1'b1, 1'b1, 64'h0);
        add_row(CMD_READ,   8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 1'b1, 1'b1, 64'h0);
        // bottom-right corner: only column 63 survives the right-edge clip
        add_row(CMD_DRAW,   8'd63,  8'd31,  4'd0,  8'hFF, 1'b0, 1'b1, 1'b0, 64'h0);
        add_row(CMD_READ,   8'd0,   8'd31,  4'd0,  8'h00, 1'b0, 1'b1, 1'b0,
                64'h8000_0000_0000_0000);
        // masked coordinates, row lands below the screen: no effect
        add_row(CMD_DRAW,   8'd255, 8'd255, 4'd1,  8'hFF, 1'b1, 1'b1, 1'b0, 64'h0);
        // overlaps column 63 lit above
        add_row(CMD_DRAW,   8'd60,  8'd31,  4'd0,  8'hFF, 1'b1, 1'b0, 1'b0, 64'h0);
        add_row(CMD_READ,   8'd0,   8'd31,  4'd0,  8'h00, 1'b0, 1'b0, 1'b0, 64'h0);
        // reads past the last line return blank, flag kept
        add_row(CMD_READ,   8'd0,   8'd32,  4'd0,  8'h00, 1'b0, 1'b1, 1'b1, 64'h0);
        add_row(CMD_READ,   8'd255, 8'd255, 4'd15, 8'hFF, 1'b1, 1'b1, 1'b1, 64'h0);
        // clear keeps the flag
        add_row(CMD_CLEAR,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 1'b1, 1'b1, 64'h0);
        add_row(CMD_READ,   8'd0,   8'd31,  4'd0,  8'h00, 1'b0, 1'b1, 1'b1, 64'h0);
        // unused command is a no-op
        add_row(CMD_UNUSED, 8'd255, 8'd255, 4'd15, 8'hFF, 1'b1, 1'b1, 1'b1, 64'h0);
        // two-row sprite with masked start, last row at offset 15
        add_row(CMD_DRAW,   8'd200, 8'd100, 4'd0,  8'hA5, 1'b0, 1'b0, 1'b0, 64'h0);
        add_row(CMD_DRAW,   8'd200, 8'd100, 4'd15, 8'h5A, 1'b1, 1'b0, 1'b0, 64'h0);
        add_row(CMD_DRAW,   8'd8,   8'd4,   4'd0,  8'hFF, 1'b1, 1'b0, 1'b0, 64'h0);
        add_row(CMD_READ,   8'd0,   8'd4,   4'd0,  8'h00, 1'b0, 1'b0, 1'b0, 64'h0);
        add_row(CMD_READ,   8'd0,   8'd19,  4'd0,  8'h00, 1'b0, 1'b0, 1'b0, 64'h0);
        // offset 15 from line 17 is clipped at the bottom
        add_row(CMD_DRAW,   8'd0,   8'd17,  4'd15, 8'hFF, 1'b1, 1'b0, 1'b0, 64'h0);
        add_row(CMD_CLEAR,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 1'b0, 1'b0, 64'h0);
        add_row(CMD_READ,   8'd0,   8'd4,   4'd0,  8'h00, 1'b0, 1'b0, 1'b0, 64'h0);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: stall changes on the falling edge. Random stall bursts,
    // or one long hold-off when the sender asks for it.
    // ------------------------------------------------------------------
    initial
    begin : rx_stall_gen
        forever
        begin
            @(negedge clk);
            if (hold_request) begin
                rsp_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                rsp_stall = 1'b1;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end else begin
                rsp_stall = 1'b0;
            end
        end
    end

    // Response checker: each accepted response against the oldest expectation.
    always @(posedge clk)
    begin : check_rsp
        sxb_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (pending_rsps.size() == 0) begin
                report_mismatch("unexpected response", rsp.line_pixels, 64'h0);
            end else begin
                want = pending_rsps.pop_front();
                if (rsp.collision !== want.collision)
                    report_mismatch("collision", 64'(rsp.collision), 64'(want.collision));
                if (rsp.line_pixels !== want.line_pixels)
                    report_mismatch("line_pixels", rsp.line_pixels, want.line_pixels);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random traffic, wind-down.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int  pick;
        int  next_mode_change;
        bit  hold_done;
        bit  drain_done;
        for (int i = 0; i < SCREEN_LINES; i++)
            frame_model[i] = '0;
        hit_model        = 1'b0;
        next_mode_change = 0;
        hold_done        = 1'b0;
        drain_done       = 1'b0;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        load_directed();
        foreach (stim_table[i])
            send_req(stim_table[i].r, stim_table[i].typed, stim_table[i].rsp);

        reqs_sent = 0;
        while (reqs_sent < RANDOM_REQS)
        begin
            // Idling switches on and off in stretches; the tail runs flat out.
            if (reqs_sent >= QUIET_FROM) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end else if (reqs_sent >= next_mode_change) begin
                tx_idle_en       = ($urandom_range(0, 2) != 0);
                rx_idle_en       = ($urandom_range(0, 2) != 0);
                next_mode_change = reqs_sent + 100;
            end

            // Long receiver hold-off while the sender keeps offering
            // back-to-back requests, so the block backs up into its input.
            if (!hold_done && reqs_sent >= HOLD_AT) begin
                hold_done    = 1'b1;
                hold_request = 1'b1;
                tx_idle_en   = 1'b0;
                repeat (4) draw_sprite(1'b0);
                tx_idle_en   = 1'b1;
            end

            if (!drain_done && reqs_sent >= DRAIN_AT) begin
                drain_done = 1'b1;
                drain_rsps();
            end

            pick = $urandom_range(0, 99);
            if (pick < 60)
                draw_sprite(1'b0);
            else if (pick < 70)
                draw_sprite(1'b1);
            else if (pick < 85)
                send(mk_req(CMD_READ, 8'($urandom),
                            ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, 33)),
                            4'($urandom), 8'($urandom), 1'($urandom)));
            else if (pick < 88)
                send(mk_req(CMD_CLEAR, 8'($urandom), 8'($urandom), 4'($urandom),
                            8'($urandom), 1'($urandom)));
            else if (pick < 96)
                send(mk_req(2'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
                            8'($urandom), 1'($urandom)));
            else
                send(mk_req(CMD_UNUSED, 8'($urandom), 8'($urandom), 4'($urandom),
                            8'($urandom), 1'($urandom)));
        end

        drain_rsps();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("sprite_xor_blitter_unit test passed");
        else
            $display("sprite_xor_blitter_unit test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin : watchdog
        #5_000_000;
        $display("sprite_xor_blitter_unit test failed");
        $finish;
    end

endmodule
